### rtl/core/tldmc_pkg.sv
// Shared types and constants for the three-level direct-mapped cache.
package tldmc_pkg;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int TAG_SHIFT   = 6;
  localparam int TAG_W       = ADDR_W - TAG_SHIFT;
  localparam int COST_W      = 8;
  localparam int CNT_W       = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int LEVEL_W     = 2;

  localparam int FIRST_LINES_DEF  = 64;
  localparam int SECOND_LINES_DEF = 256;
  localparam int THIRD_LINES_DEF  = 1024;
  localparam int MEMORY_BYTES_DEF = 65536;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COST_FIRST  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COST_SECOND = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_COST_THIRD  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_COST_MEMORY = CFG_INDEX_W'(3);

  localparam logic [COST_W-1:0] COST_FIRST_RST  = COST_W'(1);
  localparam logic [COST_W-1:0] COST_SECOND_RST = COST_W'(3);
  localparam logic [COST_W-1:0] COST_THIRD_RST  = COST_W'(10);
  localparam logic [COST_W-1:0] COST_MEMORY_RST = COST_W'(100);

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Serving level codes
  localparam logic [LEVEL_W-1:0] LVL_FIRST  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_SECOND = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_THIRD  = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_MEMORY = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [LEVEL_W-1:0] served_from;
    logic [COST_W-1:0]  access_cost;
    logic [CNT_W-1:0]   access_total;
    logic [CNT_W-1:0]   total_cost;
    logic [CNT_W-1:0]   first_hits;
    logic [CNT_W-1:0]   first_misses;
    logic [CNT_W-1:0]   second_hits;
    logic [CNT_W-1:0]   second_misses;
    logic [CNT_W-1:0]   third_hits;
    logic [CNT_W-1:0]   third_misses;
  } rsp_t;

endpackage

### rtl/core/tldmc_ifs.sv
// Request, response and configuration channel interfaces.
interface tldmc_req_if;
  logic                 valid;
  logic                 ready;
  tldmc_pkg::req_t      payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tldmc_rsp_if;
  logic                 valid;
  logic                 ready;
  tldmc_pkg::rsp_t      payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tldmc_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [tldmc_pkg::CFG_INDEX_W-1:0]        index;
  logic [tldmc_pkg::COST_W-1:0]             data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/three_level_direct_mapped_cache.sv
// Byte cache with three direct-mapped levels in front of a backing memory. After reset the
// block sweeps every memory to zero, one address a cycle, and takes no request meanwhile;
// configuration writes are taken at all times. After a request is accepted, a read walks the
// levels one per cycle over a single shared tag comparator and a single counter incrementer
// until a level or the memory serves it, while a write updates all three levels and the
// memory together; then the result is posted. A finished result waits in the output register
// until taken, and the next request is not accepted until it has been loaded.
module three_level_direct_mapped_cache #(
  parameter int FIRST_LINES  = tldmc_pkg::FIRST_LINES_DEF,
  parameter int SECOND_LINES = tldmc_pkg::SECOND_LINES_DEF,
  parameter int THIRD_LINES  = tldmc_pkg::THIRD_LINES_DEF,
  parameter int MEMORY_BYTES = tldmc_pkg::MEMORY_BYTES_DEF
) (
  input logic         clk,
  input logic         rst,
  tldmc_req_if.sink   req,
  tldmc_rsp_if.source rsp,
  tldmc_cfg_if.sink   cfg
);
  import tldmc_pkg::*;

  localparam int L1_AW  = $clog2(FIRST_LINES);
  localparam int L2_AW  = $clog2(SECOND_LINES);
  localparam int L3_AW  = $clog2(THIRD_LINES);
  localparam int MEM_AW = $clog2(MEMORY_BYTES);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;

  // Configuration registers
  logic [COST_W-1:0] cost_first, cost_second, cost_third, cost_memory;

  // Latched request and lookup progress
  logic               func_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [DATA_W-1:0]  wdata_q;
  logic [LEVEL_W-1:0] lvl;
  logic [DATA_W-1:0]  data_q;
  logic [LEVEL_W-1:0] served_q;
  logic [COST_W-1:0]  cost_q;
  logic [MEM_AW-1:0]  clr_addr;

  // Counters
  logic [CNT_W-1:0] access_cnt;
  logic [CNT_W-1:0] cost_cnt;
  logic [CNT_W-1:0] hm_cnt [6];

  // Storage
  logic [LINE_W-1:0] l1_mem [FIRST_LINES];
  logic [LINE_W-1:0] l2_mem [SECOND_LINES];
  logic [LINE_W-1:0] l3_mem [THIRD_LINES];
  logic [DATA_W-1:0] bk_mem [MEMORY_BYTES];
  line_t             l1_q, l2_q, l3_q;
  logic [DATA_W-1:0] bk_q;

  logic [ADDR_W-1:0] rd_addr;
  logic              l1_we, l2_we, l3_we, bk_we;
  logic [L1_AW-1:0]  l1_wa;
  logic [L2_AW-1:0]  l2_wa;
  logic [L3_AW-1:0]  l3_wa;
  logic [MEM_AW-1:0] bk_wa;
  line_t             line_wd;
  logic [DATA_W-1:0] bk_wd;

  // Shared comparator and incrementer
  line_t             cur_line;
  logic [TAG_W-1:0]  tag_q;
  logic              cur_hit;
  logic              found;
  logic [DATA_W-1:0] found_data;
  logic [COST_W-1:0] found_cost;
  logic [2:0]        cnt_sel;
  logic [CNT_W-1:0]  cnt_inc;

  logic req_acc, rsp_acc, out_valid, look_read, load_out;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign req_acc   = req.valid && req.ready;
  assign rsp_acc   = out_valid && rsp.ready;
  assign look_read = (state == S_LOOK) && (func_q == FUNC_READ);
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  assign rd_addr = (state == S_IDLE) ? req.payload.address : addr_q;
  assign tag_q   = addr_q[ADDR_W-1:TAG_SHIFT];

  always_comb begin
    case (lvl)
      LVL_FIRST:  cur_line = l1_q;
      LVL_SECOND: cur_line = l2_q;
      default:    cur_line = l3_q;
    endcase
  end

  assign cur_hit = cur_line.valid && (cur_line.tag == tag_q);
  assign found   = (lvl == LVL_MEMORY) || cur_hit;
  assign found_data = (lvl == LVL_MEMORY) ? bk_q : cur_line.data;
  assign cnt_sel = {lvl, !cur_hit};
  assign cnt_inc = hm_cnt[cnt_sel] + CNT_W'(1);

  always_comb begin
    case (lvl)
      LVL_FIRST:  found_cost = cost_first;
      LVL_SECOND: found_cost = cost_second;
      LVL_THIRD:  found_cost = cost_third;
      default:    found_cost = cost_memory;
    endcase
  end

  // Memory write port control: clearing sweep, write-through, or fill on read
  always_comb begin
    l1_we   = 1'b0;
    l2_we   = 1'b0;
    l3_we   = 1'b0;
    bk_we   = 1'b0;
    l1_wa   = addr_q[L1_AW-1:0];
    l2_wa   = addr_q[L2_AW-1:0];
    l3_wa   = addr_q[L3_AW-1:0];
    bk_wa   = addr_q[MEM_AW-1:0];
    line_wd = '{valid: 1'b1, tag: tag_q, data: found_data};
    bk_wd   = wdata_q;
    if (state == S_CLEAR) begin
      l1_we   = 1'b1;
      l2_we   = 1'b1;
      l3_we   = 1'b1;
      bk_we   = 1'b1;
      l1_wa   = clr_addr[L1_AW-1:0];
      l2_wa   = clr_addr[L2_AW-1:0];
      l3_wa   = clr_addr[L3_AW-1:0];
      bk_wa   = clr_addr;
      line_wd = '0;
      bk_wd   = '0;
    end else if (state == S_LOOK && func_q == FUNC_WRITE) begin
      l1_we   = 1'b1;
      l2_we   = 1'b1;
      l3_we   = 1'b1;
      bk_we   = 1'b1;
      line_wd = '{valid: 1'b1, tag: tag_q, data: wdata_q};
    end else if (look_read && found) begin
      // fill every level above the one that served
      l1_we = (lvl != LVL_FIRST);
      l2_we = lvl inside {LVL_THIRD, LVL_MEMORY};
      l3_we = (lvl == LVL_MEMORY);
    end
  end

  always_ff @(posedge clk) begin
    if (l1_we) l1_mem[l1_wa] <= line_wd;
    l1_q <= l1_mem[rd_addr[L1_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (l2_we) l2_mem[l2_wa] <= line_wd;
    l2_q <= l2_mem[rd_addr[L2_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (l3_we) l3_mem[l3_wa] <= line_wd;
    l3_q <= l3_mem[rd_addr[L3_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bk_we) bk_mem[bk_wa] <= bk_wd;
    bk_q <= bk_mem[rd_addr[MEM_AW-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cost_first  <= COST_FIRST_RST;
      cost_second <= COST_SECOND_RST;
      cost_third  <= COST_THIRD_RST;
      cost_memory <= COST_MEMORY_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_COST_FIRST:  cost_first  <= cfg.data;
        REG_COST_SECOND: cost_second <= cfg.data;
        REG_COST_THIRD:  cost_third  <= cfg.data;
        REG_COST_MEMORY: cost_memory <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      lvl        <= LVL_FIRST;
      out_valid  <= 1'b0;
      access_cnt <= '0;
      cost_cnt   <= '0;
      for (int i = 0; i < 6; i++) hm_cnt[i] <= '0;
    end else begin
      if (load_out)     out_valid <= 1'b1;
      else if (rsp_acc) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MEM_AW'(1);
          if (clr_addr == MEM_AW'(MEMORY_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_acc) begin
            lvl   <= LVL_FIRST;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (func_q == FUNC_WRITE) begin
            state <= S_DONE;
          end else begin
            if (lvl != LVL_MEMORY) hm_cnt[cnt_sel] <= cnt_inc;
            if (found) state <= S_DONE;
            else       lvl   <= lvl + LEVEL_W'(1);
          end
        end
        S_DONE: begin
          if (load_out) begin
            access_cnt <= access_cnt + CNT_W'(1);
            cost_cnt   <= cost_cnt + CNT_W'(cost_q);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request and result payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      func_q  <= req.payload.func;
      addr_q  <= req.payload.address;
      wdata_q <= req.payload.write_data;
    end
    if (state == S_LOOK) begin
      if (func_q == FUNC_WRITE) begin
        data_q   <= wdata_q;
        served_q <= LVL_FIRST;
        cost_q   <= cost_first;
      end else if (found) begin
        data_q   <= found_data;
        served_q <= lvl;
        cost_q   <= found_cost;
      end
    end
    if (load_out) begin
      rsp.payload <= '{
        read_data:      data_q,
        served_from:    served_q,
        access_cost:    cost_q,
        access_total:   access_cnt + CNT_W'(1),
        total_cost:     cost_cnt + CNT_W'(cost_q),
        first_hits:     hm_cnt[0],
        first_misses:   hm_cnt[1],
        second_hits:    hm_cnt[2],
        second_misses:  hm_cnt[3],
        third_hits:     hm_cnt[4],
        third_misses:   hm_cnt[5]
      };
    end
  end

  // Every first-level miss is counted at the second level, and likewise below
  a_l2_balance: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.payload.first_misses ==
                  rsp.payload.second_hits + rsp.payload.second_misses)
    else $error("second-level counts do not match first-level misses");

  a_l3_balance: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.payload.second_misses ==
                  rsp.payload.third_hits + rsp.payload.third_misses)
    else $error("third-level counts do not match second-level misses");

  a_accept_looks: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_LOOK && lvl == LVL_FIRST))
    else $error("accepted transaction did not start a lookup");

  a_write_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && func_q == FUNC_WRITE) |=> served_q == LVL_FIRST)
    else $error("write not reported as served by the first level");

endmodule

### sim/tb_three_level_direct_mapped_cache.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-level direct-mapped byte cache.
module tb_three_level_direct_mapped_cache;
  import tldmc_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int LONG_HOLD       = 400;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int NUM_PHASES      = 5;
  localparam int HOT_ADDRS       = 16;

  logic clk = 1'b0;
  logic rst;

  tldmc_req_if req_ch ();
  tldmc_rsp_if rsp_ch ();
  tldmc_cfg_if cfg_ch ();

  three_level_direct_mapped_cache u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cache image kept alongside the block
  line_t             first_lv  [FIRST_LINES_DEF];
  line_t             second_lv [SECOND_LINES_DEF];
  line_t             third_lv  [THIRD_LINES_DEF];
  logic [DATA_W-1:0] mem_img   [MEMORY_BYTES_DEF];
  logic [COST_W-1:0] cost_by_level [4];
  logic [CNT_W-1:0]  accesses, cost_sum;
  logic [CNT_W-1:0]  l1_hits, l1_misses, l2_hits, l2_misses, l3_hits, l3_misses;

  req_t              pending_req [$];
  rsp_t              expected_rsp [$];
  logic [ADDR_W-1:0] hot_addr [HOT_ADDRS];
  logic              no_idle;
  int                mismatches = 0;
  int                send_gap;
  int                ready_hold;
  int                results_seen = 0;
  int                idle_cycles = 0;

  function automatic rsp_t model_access(input req_t r);
    rsp_t             o;
    logic [TAG_W-1:0] tag;
    logic [5:0]       i1;
    logic [7:0]       i2;
    logic [9:0]       i3;
    tag = r.address[ADDR_W-1:TAG_SHIFT];
    i1  = r.address[5:0];
    i2  = r.address[7:0];
    i3  = r.address[9:0];
    o   = '0;
    accesses = accesses + 1;
    if (r.func == FUNC_WRITE) begin
      first_lv[i1]  = '{valid: 1'b1, tag: tag, data: r.write_data};
      second_lv[i2] = '{valid: 1'b1, tag: tag, data: r.write_data};
      third_lv[i3]  = '{valid: 1'b1, tag: tag, data: r.write_data};
      mem_img[r.address] = r.write_data;
      o.read_data   = r.write_data;
      o.served_from = LVL_FIRST;
    end else if (first_lv[i1].valid && first_lv[i1].tag == tag) begin
      l1_hits++;
      o.read_data   = first_lv[i1].data;
      o.served_from = LVL_FIRST;
    end else begin
      l1_misses++;
      if (second_lv[i2].valid && second_lv[i2].tag == tag) begin
        l2_hits++;
        o.read_data   = second_lv[i2].data;
        o.served_from = LVL_SECOND;
      end else begin
        l2_misses++;
        if (third_lv[i3].valid && third_lv[i3].tag == tag) begin
          l3_hits++;
          o.read_data   = third_lv[i3].data;
          o.served_from = LVL_THIRD;
        end else begin
          l3_misses++;
          o.read_data   = mem_img[r.address];
          o.served_from = LVL_MEMORY;
          third_lv[i3]  = '{valid: 1'b1, tag: tag, data: o.read_data};
        end
        second_lv[i2] = '{valid: 1'b1, tag: tag, data: o.read_data};
      end
      first_lv[i1] = '{valid: 1'b1, tag: tag, data: o.read_data};
    end
    o.access_cost    = cost_by_level[o.served_from];
    cost_sum         = cost_sum + o.access_cost;
    o.access_total   = accesses;
    o.total_cost     = cost_sum;
    o.first_hits     = l1_hits;
    o.first_misses   = l1_misses;
    o.second_hits    = l2_hits;
    o.second_misses  = l2_misses;
    o.third_hits     = l3_hits;
    o.third_misses   = l3_misses;
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void check_field(input string fname, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // Mostly reuse a few hot addresses and their aliases so that every level gets hits.
  function automatic req_t random_access();
    req_t r;
    int   pick;
    pick         = $urandom_range(0, 99);
    r.func       = ($urandom_range(0, 99) < 30) ? FUNC_WRITE : FUNC_READ;
    r.write_data = DATA_W'($urandom);
    if (pick < 35)
      r.address = hot_addr[$urandom_range(0, HOT_ADDRS - 1)];
    else if (pick < 60)
      r.address = hot_addr[$urandom_range(0, HOT_ADDRS - 1)] ^
                  (ADDR_W'($urandom_range(1, 15)) << TAG_SHIFT);
    else if (pick < 75)
      r.address = hot_addr[$urandom_range(0, HOT_ADDRS - 1)] ^
                  (ADDR_W'($urandom_range(16, 1023)) << TAG_SHIFT);
    else
      r.address = ADDR_W'($urandom);
    return r;
  endfunction

  task automatic push_access(input logic func, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    req_t r;
    r.func       = func;
    r.address    = addr;
    r.write_data = wdata;
    pending_req.push_back(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COST_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_COST_FIRST:  cost_by_level[LVL_FIRST]  = val;
      REG_COST_SECOND: cost_by_level[LVL_SECOND] = val;
      REG_COST_THIRD:  cost_by_level[LVL_THIRD]  = val;
      REG_COST_MEMORY: cost_by_level[LVL_MEMORY] = val;
      default: ;
    endcase
  endtask

  task automatic set_costs(input logic [COST_W-1:0] c1, input logic [COST_W-1:0] c2,
                           input logic [COST_W-1:0] c3, input logic [COST_W-1:0] cm);
    write_reg(REG_COST_FIRST, c1);
    write_reg(REG_COST_SECOND, c2);
    write_reg(REG_COST_THIRD, c3);
    write_reg(REG_COST_MEMORY, cm);
  endtask

  // Request driver
  always @(posedge clk) begin : req_driver
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_rsp.push_back(model_access(req_ch.payload));
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_req.size() != 0) begin
          req_ch.payload <= pending_req.pop_front();
          req_ch.valid   <= 1'b1;
          send_gap = no_idle ? 0 : pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and ready generator
  always @(posedge clk) begin : rsp_monitor
    rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_rsp.size() == 0) begin
          $display("%0t: transaction with no expectation, read_data %0h", $time,
                   rsp_ch.payload.read_data);
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("read_data", want.read_data, rsp_ch.payload.read_data);
          check_field("served_from", want.served_from, rsp_ch.payload.served_from);
          check_field("access_cost", want.access_cost, rsp_ch.payload.access_cost);
          check_field("access_total", want.access_total, rsp_ch.payload.access_total);
          check_field("total_cost", want.total_cost, rsp_ch.payload.total_cost);
          check_field("first_hits", want.first_hits, rsp_ch.payload.first_hits);
          check_field("first_misses", want.first_misses, rsp_ch.payload.first_misses);
          check_field("second_hits", want.second_hits, rsp_ch.payload.second_hits);
          check_field("second_misses", want.second_misses, rsp_ch.payload.second_misses);
          check_field("third_hits", want.third_hits, rsp_ch.payload.third_hits);
          check_field("third_misses", want.third_misses, rsp_ch.payload.third_misses);
        end
        // Hold off long enough for the block to back up into its input
        if (results_seen == 300 || results_seen == 1500)
          ready_hold = LONG_HOLD;
      end
      if (ready_hold > 0) begin
        ready_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (no_idle) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        ready_hold = pick_gap();
        rsp_ch.ready <= (ready_hold == 0);
      end
    end
  end

  // Watchdog on transaction progress; the clearing sweep after reset fits well inside it
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    no_idle        = 1'b0;

    for (int i = 0; i < FIRST_LINES_DEF; i++) first_lv[i] = '0;
    for (int i = 0; i < SECOND_LINES_DEF; i++) second_lv[i] = '0;
    for (int i = 0; i < THIRD_LINES_DEF; i++) third_lv[i] = '0;
    for (int i = 0; i < MEMORY_BYTES_DEF; i++) mem_img[i] = '0;
    cost_by_level[LVL_FIRST]  = COST_FIRST_RST;
    cost_by_level[LVL_SECOND] = COST_SECOND_RST;
    cost_by_level[LVL_THIRD]  = COST_THIRD_RST;
    cost_by_level[LVL_MEMORY] = COST_MEMORY_RST;
    accesses  = '0;
    cost_sum  = '0;
    l1_hits   = '0;
    l1_misses = '0;
    l2_hits   = '0;
    l2_misses = '0;
    l3_hits   = '0;
    l3_misses = '0;
    for (int i = 0; i < HOT_ADDRS; i++) hot_addr[i] = ADDR_W'($urandom);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: ;
        1: begin
          set_costs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
          // out-of-range indexes must leave the costs alone
          write_reg(CFG_INDEX_W'(4), 8'h00);
          write_reg(8'hFF, 8'h00);
        end
        2: set_costs(8'h00, 8'h00, 8'h00, 8'h00);
        3: set_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom),
                     COST_W'($urandom));
        default: begin
          write_reg(CFG_INDEX_W'($urandom_range(4, 255)), COST_W'($urandom));
          set_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom),
                    COST_W'($urandom));
        end
      endcase
      @(negedge clk);
      no_idle = (phase == 2);
      if (phase == 0) begin
        push_access(FUNC_READ, 16'h0000, 8'h00);   // cold read of cleared memory
        push_access(FUNC_READ, 16'hFFFF, 8'hFF);   // write data ignored on a read
        push_access(FUNC_WRITE, 16'hFFFF, 8'hFF);
        push_access(FUNC_READ, 16'hFFFF, 8'h00);   // first-level hit
        push_access(FUNC_WRITE, 16'h0000, 8'h00);
        push_access(FUNC_READ, 16'h0000, 8'hFF);
        push_access(FUNC_WRITE, 16'h1234, 8'hA5);
        push_access(FUNC_WRITE, 16'h1274, 8'h5A);  // same first-level line, other second
        push_access(FUNC_READ, 16'h1234, 8'h00);   // second-level hit
        push_access(FUNC_READ, 16'h1274, 8'h00);   // second-level hit
        push_access(FUNC_WRITE, 16'h1334, 8'h3C);  // evict from first and second level
        push_access(FUNC_READ, 16'h1234, 8'h00);   // third-level hit
        push_access(FUNC_WRITE, 16'h1634, 8'hC3);  // evict from all three levels
        push_access(FUNC_READ, 16'h1234, 8'h00);   // served by memory
        push_access(FUNC_READ, 16'h1234, 8'h00);   // first-level hit after fill
        push_access(FUNC_READ, 16'h8000, 8'h00);
        push_access(FUNC_READ, 16'hFFC0, 8'h00);   // tag all ones, index zero
        push_access(FUNC_READ, 16'h003F, 8'h00);   // tag zero, index all ones
      end
      repeat (ITEMS_PER_PHASE) pending_req.push_back(random_access());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
